// File: design/plid_pkg.sv
package plid_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_FIND   = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // what every cell of the row does in a cycle
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_DEL  = 2'd2;
    localparam logic [1:0] CELL_ROT  = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] value;
    } cell_ctrl_t;

endpackage

// File: design/positional_list_insert_delete_find.sv
// Bounded list of CAPACITY signed 32-bit entries held in a row of cells, one
// entry per cell. Insert and clear go from the accepted beat to S_FINISH; find
// and delete first pass through S_SCAN, where the row turns once as a ring
// through cell 0, where the match or the entry to remove is seen; a delete then
// shifts the row down in one step. One command is in flight at once; the result
// register lets the next command be accepted while a result waits to be taken.
module positional_list_insert_delete_find #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [6:0]         position,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] removed_value,
    output logic [6:0]         found_position,
    output logic [6:0]         count
);
    import plid_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = ((LW > 7) ? LW : 7) + 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [LW-1:0] length_reg, length_next;
    logic [IW-1:0] scan_reg, scan_next;
    logic          hit_reg, hit_next;
    logic [LW-1:0] found_reg, found_next;
    logic [31:0]   taken_reg, taken_next;
    logic [1:0]    cmd_reg;
    logic [6:0]    pos_reg;
    logic [31:0]   value_reg;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    status_reg, status_next;
    logic [31:0]   removed_reg, removed_next;
    logic [6:0]    found_pos_reg, found_pos_next;
    logic [6:0]    count_reg, count_next;

    logic [31:0]   cell_data [CAPACITY];
    cell_ctrl_t    cell_ctrl;
    logic [IW-1:0] pos_idx;

    logic [CW-1:0] len_x, pos_x, scan_x;
    logic          accept, out_free, finish;
    logic          ins_ok, ins_range_bad, del_ok;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign finish   = (state_reg == S_FINISH) && out_free;

    assign len_x  = CW'(length_reg);
    assign pos_x  = CW'(pos_reg);
    assign scan_x = CW'(scan_reg);

    assign ins_range_bad = (pos_x == '0) || (pos_x > len_x + CW'(1));
    assign ins_ok        = !ins_range_bad && (len_x < CW'(CAPACITY));
    assign del_ok        = (pos_x != '0) && (pos_x <= len_x);
    assign pos_idx       = IW'(pos_x - CW'(1));

    always_comb
    begin
        cell_ctrl.op    = CELL_HOLD;
        cell_ctrl.value = value_reg;
        if (state_reg == S_SCAN)
        begin
            cell_ctrl.op = CELL_ROT;
        end
        else if (finish)
        begin
            if ((cmd_reg == CMD_INSERT) && ins_ok)
            begin
                cell_ctrl.op = CELL_INS;
            end
            else if ((cmd_reg == CMD_DELETE) && del_ok)
            begin
                cell_ctrl.op = CELL_DEL;
            end
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        plid_cell #(
            .IW  (IW),
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .pos_idx    (pos_idx),
            .left_data  (cell_data[(i == 0) ? 0 : i - 1]),
            .right_data (cell_data[(i == CAPACITY - 1) ? 0 : i + 1]),
            .data       (cell_data[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        length_next    = length_reg;
        scan_next      = scan_reg;
        hit_next       = hit_reg;
        found_next     = found_reg;
        taken_next     = taken_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        removed_next   = removed_reg;
        found_pos_next = found_pos_reg;
        count_next     = count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    scan_next  = '0;
                    hit_next   = 1'b0;
                    found_next = '0;
                    taken_next = '0;
                    if ((cmd == CMD_FIND) || (cmd == CMD_DELETE))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN:
            begin
                // cell 0 holds entry scan_reg on this cycle
                if (scan_x == pos_x - CW'(1))
                begin
                    taken_next = cell_data[0];
                end
                if (!hit_reg && (scan_x < len_x) && (cell_data[0] == value_reg))
                begin
                    hit_next   = 1'b1;
                    found_next = LW'(scan_x + CW'(1));
                end
                scan_next = scan_reg + IW'(1);
                if (scan_reg == IW'(CAPACITY - 1))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    removed_next   = '0;
                    found_pos_next = '0;
                    unique case (cmd_reg)
                        CMD_INSERT:
                        begin
                            if (ins_range_bad)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (!ins_ok)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                length_next = length_reg + LW'(1);
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (del_ok)
                            begin
                                removed_next = taken_reg;
                                length_next  = length_reg - LW'(1);
                            end
                            else
                            begin
                                status_next = ST_RANGE;
                            end
                        end
                        CMD_FIND:
                        begin
                            found_pos_next = 7'(found_reg);
                        end
                        CMD_CLEAR:
                        begin
                            length_next = '0;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                    count_next = 7'(length_next);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            length_reg    <= length_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg      <= scan_next;
        hit_reg       <= hit_next;
        found_reg     <= found_next;
        taken_reg     <= taken_next;
        status_reg    <= status_next;
        removed_reg   <= removed_next;
        found_pos_reg <= found_pos_next;
        count_reg     <= count_next;
        if (accept)
        begin
            cmd_reg   <= cmd;
            pos_reg   <= position;
            value_reg <= value;
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign removed_value  = removed_reg;
    assign found_position = found_pos_reg;
    assign count          = count_reg;

endmodule

// File: design/plid_cell.sv
module plid_cell #(
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  logic                clk,
    input  plid_pkg::cell_ctrl_t ctrl,
    input  logic [IW-1:0]       pos_idx,
    input  logic [31:0]         left_data,
    input  logic [31:0]         right_data,
    output logic [31:0]         data
);
    import plid_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [31:0] data_reg;
    logic [31:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
                data_next = data_reg;
            end
            CELL_INS:
            begin
                if (MY_IDX > pos_idx)
                begin
                    data_next = left_data;
                end
                else if (MY_IDX == pos_idx)
                begin
                    data_next = ctrl.value;
                end
            end
            CELL_DEL:
            begin
                if (MY_IDX >= pos_idx)
                begin
                    data_next = right_data;
                end
            end
            CELL_ROT:
            begin
                data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: design/plid_checker.sv
module plid_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [1:0]         cmd,
    input logic [6:0]         position,
    input logic signed [31:0] value,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         status,
    input logic signed [31:0] removed_value,
    input logic [6:0]         found_position,
    input logic [6:0]         count
);
    import plid_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(removed_value) && $stable(found_position) && $stable(count))
        else $error("stalled result beat changed");

    // one command in flight: an accepted beat makes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after a beat");

    // a failed command reports no removed entry and no match
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (removed_value == 0) && (found_position == 0))
        else $error("failed command carries data");

    // a match position and a removed entry never come from one command
    a_find_no_remove: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (found_position != 0) |-> (removed_value == 0) && (status == ST_OK))
        else $error("find result carries removed entry");

endmodule

bind positional_list_insert_delete_find plid_checker u_plid_checker (.*);

// File: sim/list_result_checker.sv
module list_result_checker #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [6:0]         position,
    input  logic signed [31:0] value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [1:0]         status,
    input  logic signed [31:0] removed_value,
    input  logic [6:0]         found_position,
    input  logic [6:0]         count,
    output int                 fail_count,
    output int                 pending,
    output int                 list_len
);
    timeunit 1ns;
    timeprecision 1ps;

    import plid_pkg::*;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_value;
        logic [6:0]         found_position;
        logic [6:0]         count;
    } list_result_t;

    logic [31:0]  list_entries [CAPACITY];
    int           entry_count;
    list_result_t expected_results [$];
    list_result_t want;
    list_result_t got;

    function automatic list_result_t apply_list_cmd(input logic [1:0] op,
                                                    input logic [6:0] pos,
                                                    input logic [31:0] val);
        list_result_t r;
        int           i;
        int           p;
        r = '0;
        r.status = ST_OK;
        p = int'(pos);
        if (op == CMD_INSERT)
        begin
            // position check wins over the full check
            if (p < 1 || p > entry_count + 1)
                r.status = ST_RANGE;
            else if (entry_count >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                for (i = entry_count; i >= p; i--)
                    list_entries[i] = list_entries[i - 1];
                list_entries[p - 1] = val;
                entry_count++;
            end
        end
        else if (op == CMD_DELETE)
        begin
            if (p < 1 || p > entry_count)
                r.status = ST_RANGE;
            else
            begin
                r.removed_value = list_entries[p - 1];
                for (i = p; i < entry_count; i++)
                    list_entries[i - 1] = list_entries[i];
                entry_count--;
            end
        end
        else if (op == CMD_FIND)
        begin
            for (i = 0; i < entry_count; i++)
            begin
                if (list_entries[i] == val)
                begin
                    r.found_position = 7'(i + 1);
                    break;
                end
            end
        end
        else
            entry_count = 0;
        r.count = 7'(entry_count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count = 0;
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{status, removed_value, found_position, count};
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result beat with nothing expected: status %0d removed %0d found %0d count %0d",
                                 $time, got.status, got.removed_value, got.found_position,
                                 got.count);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status
                        || got.removed_value !== want.removed_value
                        || got.found_position !== want.found_position
                        || got.count !== want.count)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: mismatch expected status %0d removed %0d found %0d count %0d",
                                     $time, want.status, want.removed_value,
                                     want.found_position, want.count);
                            $display("%0t:          actual   status %0d removed %0d found %0d count %0d",
                                     $time, got.status, got.removed_value,
                                     got.found_position, got.count);
                        end
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(apply_list_cmd(cmd, position, value));
        end
        pending  = expected_results.size();
        list_len = entry_count;
    end

endmodule

// File: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import plid_pkg::*;

    localparam int CAPACITY = 64;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [1:0]         cmd       = CMD_FIND;
    logic [6:0]         position  = '0;
    logic signed [31:0] value     = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [6:0]         found_position;
    logic [6:0]         count;

    int          fail_count;
    int          pending;
    int          list_len;
    int          send_idle = 26;
    int          recv_idle = 79;
    logic [31:0] value_pool [8];

    positional_list_insert_delete_find #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .position      (position),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .removed_value (removed_value),
        .found_position(found_position),
        .count         (count)
    );

    list_result_checker #(
        .CAPACITY(CAPACITY)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .position      (position),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .removed_value (removed_value),
        .found_position(found_position),
        .count         (count),
        .fail_count    (fail_count),
        .pending       (pending),
        .list_len      (list_len)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(99) < recv_idle);

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_cmd(input logic [1:0] c, input logic [6:0] p, input logic [31:0] v);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        position <= p;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_for_results;
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(99) < 65)
            return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    task automatic send_random;
        int         roll;
        int         len;
        logic [1:0] c;
        logic [6:0] p;
        len  = list_len;
        roll = $urandom_range(99);
        if (roll < 40)
            c = CMD_INSERT;
        else if (roll < 65)
            c = CMD_DELETE;
        else if (roll < 97)
            c = CMD_FIND;
        else
            c = CMD_CLEAR;
        roll = $urandom_range(99);
        if (roll < 12)
            p = 7'($urandom_range(127));
        else if (c == CMD_INSERT)
            p = (roll < 25) ? 7'(len + 1) : 7'($urandom_range(len + 1, 1));
        else if (len > 0)
            p = (roll < 25) ? 7'(len) : 7'($urandom_range(len, 1));
        else
            p = 7'($urandom_range(127));
        send_cmd(c, p, pick_value());
    endtask

    task automatic fill_and_overflow;
        while (list_len < CAPACITY)
            send_cmd(CMD_INSERT, 7'($urandom_range(list_len + 1, 1)), pick_value());
        // full list: in-range positions report full, out-of-range still report range
        send_cmd(CMD_INSERT, 7'(CAPACITY + 1), pick_value());
        send_cmd(CMD_INSERT, 7'd1, pick_value());
        send_cmd(CMD_INSERT, 7'(CAPACITY + 2), pick_value());
        send_cmd(CMD_FIND, 7'($urandom_range(127)), value_pool[$urandom_range(7)]);
        send_cmd(CMD_DELETE, 7'(CAPACITY), $urandom);
        send_cmd(CMD_DELETE, 7'(CAPACITY), $urandom);
    endtask

    initial
    begin
        int k;
        int phase;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h7FFF_FFFF;
        for (k = 4; k < 8; k++)
            value_pool[k] = $urandom;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_cmd(CMD_DELETE, 7'd1, 32'd7);
        send_cmd(CMD_DELETE, 7'd0, 32'd7);
        send_cmd(CMD_FIND, 7'd0, 32'd0);
        send_cmd(CMD_INSERT, 7'd0, 32'd5);
        send_cmd(CMD_INSERT, 7'd2, 32'd5);
        send_cmd(CMD_INSERT, 7'd1, 32'h8000_0000);
        send_cmd(CMD_INSERT, 7'd2, 32'h7FFF_FFFF);
        send_cmd(CMD_INSERT, 7'd1, 32'hFFFF_FFFF);
        send_cmd(CMD_INSERT, 7'd127, 32'd9);
        send_cmd(CMD_INSERT, 7'd2, 32'd0);
        // last entry must be searched
        send_cmd(CMD_FIND, 7'd127, 32'h7FFF_FFFF);
        send_cmd(CMD_FIND, 7'd0, 32'hFFFF_FFFF);
        send_cmd(CMD_FIND, 7'd3, 32'd12345);
        send_cmd(CMD_INSERT, 7'd5, 32'hFFFF_FFFF);
        send_cmd(CMD_FIND, 7'd0, 32'hFFFF_FFFF);
        send_cmd(CMD_DELETE, 7'd6, 32'd0);
        send_cmd(CMD_DELETE, 7'd5, 32'd0);
        send_cmd(CMD_DELETE, 7'd1, 32'd0);
        send_cmd(CMD_DELETE, 7'd127, 32'd0);
        send_cmd(CMD_CLEAR, 7'd127, 32'hFFFF_FFFF);
        // old entries stay behind a clear but must not be found
        send_cmd(CMD_FIND, 7'd0, 32'd0);
        send_cmd(CMD_DELETE, 7'd1, 32'd0);
        send_cmd(CMD_INSERT, 7'd1, 32'h5555_5555);
        send_cmd(CMD_INSERT, 7'd1, 32'hAAAA_AAAA);
        send_cmd(CMD_CLEAR, 7'd0, 32'd0);
        wait_for_results();

        for (phase = 0; phase < 3; phase++)
        begin
            if (phase == 0)
            begin
                send_idle = 26;
                recv_idle = 79;
            end
            else if (phase == 1)
            begin
                send_idle = 79;
                recv_idle = 26;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (k = 4; k < 8; k++)
                value_pool[k] = $urandom;
            for (k = 0; k < 30; k++)
                send_random();
            wait_for_results();
            fill_and_overflow();
            for (k = 0; k < 30; k++)
                send_random();
            wait_for_results();
        end

        repeat (100) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: positional_list_insert_delete_find.f
design/plid_pkg.sv
design/plid_cell.sv
design/positional_list_insert_delete_find.sv
design/plid_checker.sv
sim/list_result_checker.sv
sim/testbench.sv
